[src/rc4m_pkg.sv]
// Shared constants and codes for the modified RC4 cipher block.
package rc4m_pkg;

  localparam int unsigned SBOX_SIZE_DEF = 255;
  localparam int unsigned KEY_DEPTH_DEF = 64;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [1:0] MODE_KEY   = 2'd0;
  localparam logic [1:0] MODE_SCHED = 2'd1;
  localparam logic [1:0] MODE_DATA  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ASCENDING  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENCRYPT    = 3'd4;

  localparam logic [6:0] KEY_LENGTH_RST = 7'd16;
  localparam logic       ASCENDING_RST  = 1'b1;
  localparam logic [7:0] LOW_STEP_RST   = 8'd0;
  localparam logic [7:0] OFFSET_RST     = 8'd0;
  localparam logic       ENCRYPT_RST    = 1'b1;

endpackage

[src/rc4m_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module rc4m_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/rc4m_modadd.sv]
// Shared modular adder: index plus reduced byte, modulo the S-box size.
module rc4m_modadd #(
  parameter int unsigned SBOX_SIZE = 255,
  localparam int unsigned IW = $clog2(SBOX_SIZE)
) (
  input  logic [IW-1:0] a_i,
  input  logic [7:0]    b_i,
  output logic [IW-1:0] y_o
);

  function automatic logic [255:0][IW-1:0] build_tbl();
    logic [255:0][IW-1:0] t;
    int unsigned r;
    r = 0;
    for (int unsigned v = 0; v < 256; v++) begin
      t[v] = IW'(r);
      r = (r == SBOX_SIZE - 1) ? 0 : r + 1;
    end
    return t;
  endfunction

  localparam logic [255:0][IW-1:0] RED_TBL = build_tbl();
  localparam logic [IW:0] MODULUS = (IW + 1)'(SBOX_SIZE);

  logic [IW:0] sum;

  assign sum = {1'b0, a_i} + {1'b0, RED_TBL[b_i]};
  assign y_o = (sum >= MODULUS) ? IW'(sum - MODULUS) : IW'(sum);

endmodule

[src/rc4_mod255_variant_cipher_top.sv]
// Top level of the modified RC4 cipher block with a modulo-N S-box.
// One input transaction at a time. A key-load transaction gives no result.
// A data byte passes, from acceptance until the block is ready again, through
// four dependent S-box reads and two write-backs through the
// single read and write port of the S-box RAM, each index sum through one
// shared modular adder.
// A schedule transaction fills the S-box one entry at a time, then runs the
// key pass over every entry (read, sum, j update, write i, write j), then
// gives the done result. A result waiting in the output register holds the
// block only when the next result is ready before the earlier one is taken.
module rc4_mod255_variant_cipher_top
  import rc4m_pkg::*;
#(
  parameter int unsigned SBOX_SIZE = SBOX_SIZE_DEF,
  parameter int unsigned KEY_DEPTH = KEY_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           mode_i,
  input  logic [7:0]           byte_in_i,
  input  logic [5:0]           key_index_i,
  input  logic                 message_last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           byte_out_o,
  output logic                 result_kind_o
);

  localparam int unsigned IW  = $clog2(SBOX_SIZE);
  localparam int unsigned KW  = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int unsigned KLW = (KW + 1 > 7) ? KW + 1 : 7;
  localparam logic [IW-1:0]  LAST_IDX = IW'(SBOX_SIZE - 1);
  localparam logic [KLW-1:0] KLEN_MAX = KLW'(KEY_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_K_RD,
    ST_K_SUM,
    ST_K_J,
    ST_K_WI,
    ST_K_WJ,
    ST_D_LOW,
    ST_D_HIGH,
    ST_D_RDL,
    ST_D_RDH,
    ST_D_RDM,
    ST_D_OUT,
    ST_DONE
  } st_e;

  st_e state_q;

  logic [6:0] key_length_q;
  logic       ascending_q;
  logic [7:0] low_step_q;
  logic [7:0] offset_q;
  logic       encrypt_q;

  logic [IW-1:0] pos_q;
  logic [IW-1:0] low_q;
  logic [IW-1:0] high_q;
  logic [IW-1:0] i_q;
  logic [IW-1:0] j_q;
  logic [IW-1:0] mid_q;
  logic [KW-1:0] kidx_q;
  logic [7:0]    sl_q;
  logic [7:0]    kb_q;
  logic [7:0]    byte_q;
  logic          last_q;

  logic       out_valid_q;
  logic [7:0] byte_out_q;
  logic       kind_q;

  logic [IW-1:0] add_a;
  logic [7:0]    add_b;
  logic [IW-1:0] add_y;

  logic          sb_we;
  logic [IW-1:0] sb_waddr;
  logic [7:0]    sb_wdata;
  logic [IW-1:0] sb_raddr;
  logic [7:0]    sb_rdata;

  logic          key_we;
  logic [KW-1:0] key_waddr;
  logic [7:0]    key_rdata;

  logic           in_acc;
  logic           out_free;
  logic           out_load;
  logic [KLW-1:0] klen_ext;
  logic [KLW-1:0] klen_eff;
  logic [KW-1:0]  kidx_next;
  logic [7:0]     ks_byte;
  logic [7:0]     res_byte;

  assign cfg_ready_o   = 1'b1;
  assign in_ready_o    = (state_q == ST_IDLE);
  assign in_acc        = in_valid_i && in_ready_o;
  assign out_free      = !out_valid_q || out_ready_i;
  assign out_load      = out_free && ((state_q == ST_D_OUT) || (state_q == ST_DONE));
  assign out_valid_o   = out_valid_q;
  assign byte_out_o    = byte_out_q;
  assign result_kind_o = kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= KEY_LENGTH_RST;
      ascending_q  <= ASCENDING_RST;
      low_step_q   <= LOW_STEP_RST;
      offset_q     <= OFFSET_RST;
      encrypt_q    <= ENCRYPT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_KEY_LENGTH: key_length_q <= cfg_data_i[6:0];
        CFG_ASCENDING:  ascending_q  <= cfg_data_i[0];
        CFG_LOW_STEP:   low_step_q   <= cfg_data_i;
        CFG_OFFSET:     offset_q     <= cfg_data_i;
        CFG_ENCRYPT:    encrypt_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // effective key length clamped to 1..KEY_DEPTH
  always_comb begin
    klen_ext = KLW'(key_length_q);
    if (klen_ext == '0) begin
      klen_eff = KLW'(1);
    end else if (klen_ext > KLEN_MAX) begin
      klen_eff = KLEN_MAX;
    end else begin
      klen_eff = klen_ext;
    end
    kidx_next = (KLW'(kidx_q) + KLW'(1) >= klen_eff) ? '0 : kidx_q + KW'(1);
  end

  assign key_we    = in_acc && (mode_i == MODE_KEY) && (32'(key_index_i) < KEY_DEPTH);
  assign key_waddr = KW'(key_index_i);

  rc4m_ram #(
    .WIDTH (8),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (byte_in_i),
    .raddr_i (kidx_q),
    .rdata_o (key_rdata)
  );

  rc4m_ram #(
    .WIDTH (8),
    .DEPTH (SBOX_SIZE)
  ) u_sbox_ram (
    .clk_i   (clk_i),
    .we_i    (sb_we),
    .waddr_i (sb_waddr),
    .wdata_i (sb_wdata),
    .raddr_i (sb_raddr),
    .rdata_o (sb_rdata)
  );

  rc4m_modadd #(
    .SBOX_SIZE (SBOX_SIZE)
  ) u_modadd (
    .a_i (add_a),
    .b_i (add_b),
    .y_o (add_y)
  );

  // operand and RAM port selection per step
  always_comb begin
    add_a    = pos_q;
    add_b    = 8'd1;
    sb_we    = 1'b0;
    sb_waddr = i_q;
    sb_wdata = sb_rdata;
    sb_raddr = mid_q;
    unique case (state_q)
      ST_FILL: begin
        sb_we    = 1'b1;
        sb_waddr = ascending_q ? i_q : LAST_IDX - i_q;
        sb_wdata = 8'(i_q);
      end
      ST_K_RD: begin
        sb_raddr = i_q;
      end
      ST_K_SUM: begin
        add_a = j_q;
        add_b = sb_rdata;
      end
      ST_K_J: begin
        add_a    = mid_q;
        add_b    = kb_q;
        sb_raddr = add_y;
      end
      ST_K_WI: begin
        sb_we    = 1'b1;
        sb_waddr = i_q;
        sb_wdata = sb_rdata;
      end
      ST_K_WJ: begin
        sb_we    = 1'b1;
        sb_waddr = j_q;
        sb_wdata = sl_q;
      end
      ST_D_LOW: begin
        add_a    = low_q;
        add_b    = low_step_q;
        sb_raddr = pos_q;
      end
      ST_D_HIGH: begin
        add_a    = high_q;
        add_b    = sb_rdata;
        sb_raddr = low_q;
      end
      ST_D_RDL: begin
        sb_raddr = high_q;
      end
      ST_D_RDH: begin
        add_a    = IW'(sl_q);
        add_b    = sb_rdata;
        sb_we    = 1'b1;
        sb_waddr = low_q;
        sb_wdata = sb_rdata;
      end
      ST_D_RDM: begin
        sb_we    = 1'b1;
        sb_waddr = high_q;
        sb_wdata = sl_q;
        sb_raddr = mid_q;
      end
      ST_D_OUT: begin
        add_a    = pos_q;
        add_b    = 8'd1;
        sb_raddr = mid_q;
      end
      default: ;
    endcase
  end

  // high entry write lands on the same edge as the mid read: bypass it
  assign ks_byte  = (mid_q == high_q) ? sl_q : sb_rdata;
  assign res_byte = encrypt_q ? ((byte_q ^ ks_byte) - offset_q)
                              : ((byte_q - (8'd0 - offset_q)) ^ ks_byte);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      low_q       <= '0;
      high_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      kidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            byte_q <= byte_in_i;
            last_q <= message_last_i;
            if (mode_i == MODE_SCHED) begin
              i_q     <= '0;
              state_q <= ST_FILL;
            end else if (mode_i == MODE_DATA) begin
              state_q <= ST_D_LOW;
            end
          end
        end
        ST_FILL: begin
          if (i_q == LAST_IDX) begin
            i_q     <= '0;
            j_q     <= '0;
            kidx_q  <= '0;
            state_q <= ST_K_RD;
          end else begin
            i_q <= i_q + IW'(1);
          end
        end
        ST_K_RD: begin
          state_q <= ST_K_SUM;
        end
        ST_K_SUM: begin
          sl_q    <= sb_rdata;
          kb_q    <= key_rdata;
          mid_q   <= add_y;
          state_q <= ST_K_J;
        end
        ST_K_J: begin
          j_q     <= add_y;
          state_q <= ST_K_WI;
        end
        ST_K_WI: begin
          state_q <= ST_K_WJ;
        end
        ST_K_WJ: begin
          if (i_q == LAST_IDX) begin
            state_q <= ST_DONE;
          end else begin
            i_q     <= i_q + IW'(1);
            kidx_q  <= kidx_next;
            state_q <= ST_K_RD;
          end
        end
        ST_D_LOW: begin
          low_q   <= add_y;
          state_q <= ST_D_HIGH;
        end
        ST_D_HIGH: begin
          high_q  <= add_y;
          state_q <= ST_D_RDL;
        end
        ST_D_RDL: begin
          sl_q    <= sb_rdata;
          state_q <= ST_D_RDH;
        end
        ST_D_RDH: begin
          mid_q   <= add_y;
          state_q <= ST_D_RDM;
        end
        ST_D_RDM: begin
          state_q <= ST_D_OUT;
        end
        ST_D_OUT: begin
          if (out_free) begin
            byte_out_q  <= res_byte;
            kind_q      <= KIND_DATA;
            if (last_q) begin
              pos_q  <= '0;
              low_q  <= '0;
              high_q <= '0;
            end else begin
              pos_q <= add_y;
            end
            state_q <= ST_IDLE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            byte_out_q  <= '0;
            kind_q      <= KIND_DONE;
            pos_q       <= '0;
            low_q       <= '0;
            high_q      <= '0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[src/rc4m_checker.sv]
// Port-level assertions for the modified RC4 cipher block, bound to the top level.
module rc4m_checker
  import rc4m_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [1:0] mode_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] byte_out_o,
  input logic       result_kind_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(byte_out_o) && $stable(result_kind_o))
    else $error("result transaction changed while stalled");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == KIND_DONE) |-> byte_out_o == 8'd0)
    else $error("schedule done result carries a non-zero byte");

  a_key_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == MODE_KEY || mode_i == MODE_NONE)
      |=> in_ready_o)
    else $error("key load or unused mode stalled the input");

  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == MODE_DATA || mode_i == MODE_SCHED)
      |=> !in_ready_o)
    else $error("input ready while a transaction is in progress");

endmodule

bind rc4_mod255_variant_cipher_top rc4m_checker u_rc4m_checker (.*);
